// ----- rtl/sktbl_pkg.sv -----
// shared constants and types for the sorted key table
package sktbl_pkg;
  localparam int TableDepth = 1024;
  localparam int AddrW = $clog2(TableDepth);
  localparam int CountW = AddrW + 1;
  localparam int KeyW = 32;
  localparam int LinkW = 32;
  // one memory word: key plus both links
  localparam int EntryW = KeyW + 2 * LinkW;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SET_PARENT = 2'd1,
    FUNC_SET_DOTDOT = 2'd2,
    FUNC_LOOKUP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [LinkW-1:0] parent;
    logic [LinkW-1:0] dotdot;
  } entry_t;

  // memory access request from the sequencer
  typedef struct packed {
    logic we;
    logic [AddrW-1:0] waddr;
    entry_t wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;
endpackage

// ----- rtl/sktbl_ram.sv -----
// generic single-port-write, one-read RAM with registered read data
module sktbl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/sktbl_seq.sv -----
// sequencer: binary search, shift-up insert, link update and result
module sktbl_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    func,
  input  logic [31:0]                   key,
  input  logic [31:0]                   link_value,
  output logic                          busy,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [31:0]                   found_parent,
  output logic [31:0]                   found_dotdot,
  output logic [sktbl_pkg::CountW-1:0]  entry_count,
  output sktbl_pkg::mem_req_t           req,
  input  sktbl_pkg::entry_t             rdata
);
  typedef enum logic [2:0] {
    S_IDLE, S_LAST, S_PROBE, S_CHECK, S_FIND, S_SHIFT, S_FINISH
  } state_t;

  state_t state;
  logic [1:0] op;
  logic [31:0] op_key;
  logic [31:0] op_val;
  logic [sktbl_pkg::CountW-1:0] count;
  logic [sktbl_pkg::CountW-1:0] lo;
  logic [sktbl_pkg::CountW-1:0] hi;
  logic [sktbl_pkg::CountW-1:0] ptr;
  logic [sktbl_pkg::CountW-1:0] mid;
  logic [sktbl_pkg::CountW:0] lohi;

  assign busy = (state != S_IDLE);
  assign lohi = {1'b0, lo} + {1'b0, hi};
  assign mid = lohi[sktbl_pkg::CountW:1];
  assign entry_count = count;

  // memory request: read address and write port
  always_comb begin
    req = '0;
    unique case (state)
      S_IDLE: req.raddr = sktbl_pkg::AddrW'(count - 1'b1);
      S_PROBE: req.raddr = mid[sktbl_pkg::AddrW-1:0];
      // prime the shift with the top entry in case the add misses
      S_FIND: req.raddr = sktbl_pkg::AddrW'(count - 1'b1);
      S_SHIFT: begin
        req.raddr = sktbl_pkg::AddrW'(ptr - 2'd2);
        req.we = 1'b1;
        req.waddr = ptr[sktbl_pkg::AddrW-1:0];
        req.wdata = rdata;
        if (ptr == lo) begin
          req.wdata = '{key: op_key, parent: op_val, dotdot: op_val};
        end
      end
      S_FINISH: begin
        req.raddr = ptr[sktbl_pkg::AddrW-1:0];
        req.we = (op != sktbl_pkg::FUNC_LOOKUP) && (status == sktbl_pkg::STATUS_OK);
        req.waddr = ptr[sktbl_pkg::AddrW-1:0];
        req.wdata = '{key: op_key, parent: found_parent, dotdot: found_dotdot};
      end
      default: req.raddr = ptr[sktbl_pkg::AddrW-1:0];
    endcase
  end

  // control and result registers
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          op <= func;
          op_key <= key;
          op_val <= link_value;
          lo <= '0;
          hi <= count;
          status <= sktbl_pkg::STATUS_OK;
          found_parent <= '0;
          found_dotdot <= '0;
          if (func == sktbl_pkg::FUNC_ADD) begin
            if (count == sktbl_pkg::CountW'(sktbl_pkg::TableDepth)) begin
              status <= sktbl_pkg::STATUS_FULL;
              done <= 1'b1;
              state <= S_IDLE;
            end else if (count == '0) begin
              ptr <= count;
              state <= S_SHIFT;
              lo <= count;
            end else begin
              state <= S_LAST;
            end
          end else begin
            state <= S_PROBE;
          end
        end
        S_LAST: begin
          if (rdata.key < op_key) begin
            ptr <= count;
            lo <= count;
            state <= S_SHIFT;
          end else begin
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (lo < hi) state <= S_CHECK;
          else begin
            ptr <= lo;
            state <= S_FIND;
          end
        end
        S_CHECK: begin
          if (rdata.key < op_key) lo <= mid + 1'b1;
          else hi <= mid;
          state <= S_PROBE;
        end
        S_FIND: begin
          // rdata holds entry at lo, read by the last probe step with mid equal to lo
          if (lo < count && rdata.key == op_key) begin
            if (op == sktbl_pkg::FUNC_ADD) begin
              found_parent <= op_val;
              found_dotdot <= op_val;
            end else begin
              found_parent <= (op == sktbl_pkg::FUNC_SET_PARENT) ? op_val : rdata.parent;
              found_dotdot <= (op == sktbl_pkg::FUNC_SET_DOTDOT) ? op_val : rdata.dotdot;
            end
            state <= S_FINISH;
          end else if (op == sktbl_pkg::FUNC_ADD) begin
            ptr <= count;
            state <= S_SHIFT;
          end else begin
            status <= sktbl_pkg::STATUS_NOT_FOUND;
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SHIFT: begin
          // rdata holds entry ptr-1: read by the find step on the first pass
          if (ptr == lo) begin
            count <= count + 1'b1;
            found_parent <= op_val;
            found_dotdot <= op_val;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            ptr <= ptr - 1'b1;
          end
        end
        S_FINISH: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/sorted_key_table_insert_lookup.sv -----
// top level of the sorted key table
//
// channel | signals                               | handshake
// command | start, func, key, link_value          | accepted when start && !busy
// result  | done, status, found_parent, ...       | one-cycle strobe on done
//
// binary search: one memory read per probe
// add first checks the last key; an append then skips the search
// out-of-order add also shifts one entry a cycle, top entry first, down to the insert point
// reset: synchronous, clears the count; table contents need no clearing
// results cannot be stalled
module sorted_key_table_insert_lookup (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  func,
  input  logic [31:0] key,
  input  logic [31:0] link_value,
  output logic        busy,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] found_parent,
  output logic [31:0] found_dotdot,
  output logic [10:0] entry_count
);
  sktbl_pkg::mem_req_t req;
  sktbl_pkg::entry_t rdata;
  logic [sktbl_pkg::CountW-1:0] count;
  logic [sktbl_pkg::EntryW-1:0] rword;

  assign rdata = rword;
  assign entry_count = 11'(count);

  sktbl_seq u_seq (
    .clk, .rst, .start, .func, .key, .link_value, .busy, .done, .status,
    .found_parent, .found_dotdot, .entry_count(count), .req, .rdata
  );

  // one word holds key and both links
  sktbl_ram #(.Width(sktbl_pkg::EntryW), .Depth(sktbl_pkg::TableDepth)) u_ram (
    .clk, .we(req.we), .waddr(req.waddr), .wdata(req.wdata),
    .raddr(req.raddr), .rdata(rword)
  );

  // checks
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done) else $error("start not taken");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= sktbl_pkg::CountW'(sktbl_pkg::TableDepth)) else $error("count overflow");
endmodule

// ----- tb/sv/sorted_key_table_insert_lookup_tb.sv -----
// testbench for the sorted key table: directed, random and full-table checks
`timescale 1ns / 1ps

module sorted_key_table_insert_lookup_tb;
  import sktbl_pkg::*;

  // one expected result beat
  typedef struct {
    status_t     status;
    logic [31:0] parent;
    logic [31:0] dotdot;
    logic [10:0] count;
  } table_result_t;

  // shadow table that predicts every result and checks the block against it
  class link_table_sb;
    logic [31:0] keys[TableDepth];
    logic [31:0] parents[TableDepth];
    logic [31:0] dotdots[TableDepth];
    int count;
    table_result_t pending[$];
    int errors;
    int n_checked;
    int n_full;
    int n_miss;
    int n_shift;

    function new();
      count = 0;
      errors = 0;
      n_checked = 0;
      n_full = 0;
      n_miss = 0;
      n_shift = 0;
    endfunction

    // index of the first held key that is >= k, or count
    function int first_not_below(logic [31:0] k);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (keys[mid] < k) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function bit holds(logic [31:0] k);
      int i;
      i = first_not_below(k);
      return (i < count) && (keys[i] == k);
    endfunction

    // apply one accepted command beat to the shadow table
    function void note_cmd(func_t f, logic [31:0] k, logic [31:0] v);
      table_result_t r;
      int idx;
      r.status = STATUS_OK;
      r.parent = '0;
      r.dotdot = '0;
      if (f == FUNC_ADD) begin
        if (count >= TableDepth) begin
          r.status = STATUS_FULL;
          n_full++;
        end else begin
          if (count == 0 || keys[count-1] < k) begin
            idx = count;
            count++;
          end else begin
            idx = first_not_below(k);
            if (keys[idx] != k) begin
              for (int j = count; j > idx; j--) begin
                keys[j] = keys[j-1];
                parents[j] = parents[j-1];
                dotdots[j] = dotdots[j-1];
              end
              count++;
              n_shift++;
            end
          end
          keys[idx] = k;
          parents[idx] = v;
          dotdots[idx] = v;
          r.parent = v;
          r.dotdot = v;
        end
      end else begin
        idx = first_not_below(k);
        if (idx < count && keys[idx] == k) begin
          if (f == FUNC_SET_PARENT) parents[idx] = v;
          else if (f == FUNC_SET_DOTDOT) dotdots[idx] = v;
          r.parent = parents[idx];
          r.dotdot = dotdots[idx];
        end else begin
          r.status = STATUS_NOT_FOUND;
          n_miss++;
        end
      end
      r.count = count[10:0];
      pending.push_back(r);
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(logic [1:0] st, logic [31:0] par, logic [31:0] dd,
                               logic [10:0] cnt);
      table_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d count=%0d", $time, st, cnt);
        errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (st !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, st);
        errors++;
      end
      if (par !== e.parent) begin
        $display("%0t: found_parent exp %h got %h", $time, e.parent, par);
        errors++;
      end
      if (dd !== e.dotdot) begin
        $display("%0t: found_dotdot exp %h got %h", $time, e.dotdot, dd);
        errors++;
      end
      if (cnt !== e.count) begin
        $display("%0t: entry_count exp %0d got %0d", $time, e.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic [1:0]  func;
  logic [31:0] key;
  logic [31:0] link_value;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [31:0] found_parent;
  logic [31:0] found_dotdot;
  logic [10:0] entry_count;

  link_table_sb sb;
  logic [31:0] key_pool[64];
  int cycles;

  sorted_key_table_insert_lookup u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .func(func),
    .key(key),
    .link_value(link_value),
    .busy(busy),
    .done(done),
    .status(status),
    .found_parent(found_parent),
    .found_dotdot(found_dotdot),
    .entry_count(entry_count)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, found_parent, found_dotdot, entry_count);
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 6000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // drive one command beat and wait until it is accepted
  task automatic send_cmd(func_t f, logic [31:0] k, logic [31:0] v);
    @(negedge clk);
    start <= 1'b1;
    func <= f;
    key <= k;
    link_value <= v;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_cmd(f, k, v);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      func <= 2'($urandom_range(0, 3));
      key <= $urandom;
      link_value <= $urandom;
    end
  endtask

  task automatic drain();
    idle_cycles(1);
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic func_t pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return FUNC_ADD;
    else if (r < 55) return FUNC_SET_PARENT;
    else if (r < 75) return FUNC_SET_DOTDOT;
    return FUNC_LOOKUP;
  endfunction

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return key_pool[$urandom_range(0, 63)];
  endfunction

  initial begin
    int i;
    sb = new();
    cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_LOOKUP;
    key = '0;
    link_value = '0;
    foreach (key_pool[j]) key_pool[j] = $urandom & 32'hEFFF_FFFF;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: misses on empty table, extremes, insert, overwrite, link updates
    send_cmd(FUNC_LOOKUP, 32'h0000_0005, 32'h0);
    send_cmd(FUNC_SET_PARENT, 32'h0000_0005, 32'hFFFF_FFFF);
    send_cmd(FUNC_SET_DOTDOT, 32'h0000_0005, 32'hFFFF_FFFF);
    send_cmd(FUNC_ADD, 32'h0000_0000, 32'h0000_0000);
    send_cmd(FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(FUNC_ADD, 32'h8000_0000, 32'h5555_AAAA);
    send_cmd(FUNC_ADD, 32'h8000_0000, 32'hAAAA_5555);
    send_cmd(FUNC_ADD, 32'h4000_0000, 32'h1234_5678);
    send_cmd(FUNC_SET_PARENT, 32'h8000_0000, 32'hDEAD_BEEF);
    send_cmd(FUNC_SET_DOTDOT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(FUNC_SET_DOTDOT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_cmd(FUNC_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF);
    send_cmd(FUNC_LOOKUP, 32'h0000_0000, 32'h0);
    send_cmd(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_cmd(FUNC_LOOKUP, 32'h0000_0007, 32'h0);
    send_cmd(FUNC_SET_PARENT, 32'h7FFF_FFFF, 32'h1);
    send_cmd(FUNC_ADD, 32'h0000_0001, 32'h8000_0001);
    send_cmd(FUNC_LOOKUP, 32'h4000_0000, 32'h0);

    // random: mostly keys from a small pool so updates and lookups hit
    for (i = 0; i < 1200; i++) begin
      if (i == 600) drain();
      if ((i < 500 || i > 900) && $urandom_range(0, 99) < 10)
        idle_cycles($urandom_range(1, 4));
      send_cmd(pick_func(), pick_key(), $urandom);
    end

    // fill up with keys just below the top one so each insert shifts little
    i = 0;
    while (sb.count < TableDepth) begin
      send_cmd(FUNC_ADD, 32'hF000_0000 + i, $urandom);
      i++;
    end

    // full table: adds refused even on a held key
    send_cmd(FUNC_ADD, 32'hFFFF_FFFF, 32'h1111_1111);
    send_cmd(FUNC_ADD, 32'h0000_0002, 32'h2222_2222);
    send_cmd(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    for (i = 0; i < 40; i++) begin
      if ($urandom_range(0, 99) < 10) idle_cycles($urandom_range(1, 4));
      send_cmd(pick_func(), pick_key(), $urandom);
    end

    drain();
    idle_cycles(2200);

    $display("checked %0d results: %0d inserts with shift, %0d misses, %0d full refusals",
             sb.n_checked, sb.n_shift, sb.n_miss, sb.n_full);
    $display("table ended with %0d entries", sb.count);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
